// File: hdl/string_table_text_tokenizer_assert.svh
// Assertion macros for the string table tokenizer.
// They rely on clk and arst_n being visible where they are used.
`ifndef STRING_TABLE_TEXT_TOKENIZER_ASSERT_SVH
`define STRING_TABLE_TEXT_TOKENIZER_ASSERT_SVH

// Same-cycle implication, idle during reset.
`define STT_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, idle during reset.
`define STT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/stt_pkg.sv
`default_nettype none
package stt_pkg;

	localparam int NAME_MAX_DEF    = 64;
	localparam int STORE_BYTES_DEF = 65536;
	localparam int FILL_W          = 16;
	localparam int CNT_W           = 7;

	typedef enum logic [3:0] {
		M_BLANK = 4'd0,
		M_SLASH = 4'd1,
		M_LINE  = 4'd2,
		M_BLOCK = 4'd3,
		M_STAR  = 4'd4,
		M_NAME  = 4'd5,
		M_TEXT  = 4'd6,
		M_ESC   = 4'd7,
		M_DROP  = 4'd8,
		M_SKIP  = 4'd9
	} mode_t;

	typedef enum logic [1:0] {
		C_NAME  = 2'd0,
		C_COLON = 2'd1,
		C_QUOTE = 2'd2
	} ctx_t;

	typedef enum logic [1:0] {
		K_NAME = 2'd0,
		K_TEXT = 2'd1,
		K_DONE = 2'd2,
		K_DROP = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		E_NONE    = 3'd0,
		E_LONG    = 3'd1,
		E_NO_NAME = 3'd2,
		E_NO_COLON = 3'd3,
		E_NO_QUOTE = 3'd4,
		E_ENDED   = 3'd5
	} err_t;

	// One result item as it sits in the output queue.
	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data;
		err_t              err;
		logic [FILL_W-1:0] fill;
		logic              last;
	} res_t;

	// Output queue status seen by the input side.
	typedef struct packed {
		logic       space;
		logic [1:0] count;
	} q_stat_t;

endpackage
`default_nettype wire

// File: hdl/stt_step.sv
`default_nettype none
// Next-state and result logic for one character.
module stt_step #(
	parameter int NAME_MAX    = stt_pkg::NAME_MAX_DEF,
	parameter int STORE_BYTES = stt_pkg::STORE_BYTES_DEF
) (
	input  wire logic [7:0]                  char_in,
	input  wire logic                        end_of_input,
	input  wire stt_pkg::mode_t              mode,
	input  wire stt_pkg::ctx_t               ctx,
	input  wire logic [stt_pkg::CNT_W-1:0]   cnt,
	input  wire logic [stt_pkg::FILL_W-1:0]  fill,
	output stt_pkg::mode_t                   mode_nx,
	output stt_pkg::ctx_t                    ctx_nx,
	output logic [stt_pkg::CNT_W-1:0]        cnt_nx,
	output logic [stt_pkg::FILL_W-1:0]       fill_nx,
	output logic [1:0]                       nres,
	output stt_pkg::res_t                    r0,
	output stt_pkg::res_t                    r1
);
	import stt_pkg::*;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_T     = 8'h74;
	localparam logic [FILL_W:0] FILL_TOP = (FILL_W+1)'(STORE_BYTES - 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(NAME_MAX);

	function automatic logic is_name_char(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h30 && c <= 8'h39) || c == CH_UNDER;
	endfunction

	function automatic res_t mk(input kind_t k, input logic [7:0] d, input err_t e,
	                            input logic [FILL_W-1:0] f);
		res_t r;
		r.kind = k;
		r.data = d;
		r.err  = e;
		r.fill = f;
		r.last = 1'b0;
		return r;
	endfunction

	logic                blank_c;
	logic                run_blank;
	ctx_t                bctx;
	logic [FILL_W-1:0]   fill_inc;
	logic                in_rec;
	err_t                slash_err;

	assign blank_c  = char_in == CH_SP || char_in == CH_TAB || char_in == CH_LF ||
	                  char_in == CH_CR;
	assign fill_inc = ({1'b0, fill} == FILL_TOP) ? '0 : fill + 1'b1;
	assign slash_err = (ctx == C_COLON) ? E_NO_COLON :
	                   (ctx == C_QUOTE) ? E_NO_QUOTE : E_NO_NAME;

	always_comb begin
		case (mode)
			M_NAME, M_TEXT, M_ESC, M_DROP: in_rec = 1'b1;
			M_BLANK, M_SLASH, M_LINE, M_BLOCK, M_STAR:
				in_rec = ctx == C_COLON || ctx == C_QUOTE;
			default: in_rec = 1'b0;
		endcase
	end

	always_comb begin
		mode_nx   = mode;
		ctx_nx    = ctx;
		cnt_nx    = cnt;
		fill_nx   = fill;
		nres      = 2'd0;
		r0        = mk(K_NAME, 8'd0, E_NONE, fill);
		r1        = mk(K_NAME, 8'd0, E_NONE, fill);
		run_blank = 1'b0;
		bctx      = ctx;

		if (end_of_input) begin
			if (in_rec) begin
				r0   = mk(K_DROP, 8'd0, E_ENDED, fill);
				nres = 2'd1;
			end
			mode_nx = M_BLANK;
			ctx_nx  = C_NAME;
			cnt_nx  = '0;
			fill_nx = '0;
		end else begin
			case (mode)
				M_BLANK: begin
					run_blank = 1'b1;
				end
				M_SLASH: begin
					if (char_in == CH_SLASH) begin
						mode_nx = M_LINE;
					end else if (char_in == CH_STAR) begin
						mode_nx = M_BLOCK;
					end else begin
						// not a comment: error, and this char opens the skipped line
						r0   = mk(K_DROP, 8'd0, slash_err, fill);
						nres = 2'd1;
						if (char_in == CH_LF) begin
							mode_nx = M_BLANK;
							ctx_nx  = C_NAME;
						end else begin
							mode_nx = M_SKIP;
						end
					end
				end
				M_LINE: begin
					if (char_in == CH_LF)
						mode_nx = M_BLANK;
				end
				M_BLOCK: begin
					if (char_in == CH_STAR)
						mode_nx = M_STAR;
				end
				M_STAR: begin
					if (char_in == CH_SLASH)
						mode_nx = M_BLANK;
					else if (char_in != CH_STAR)
						mode_nx = M_BLOCK;
				end
				M_NAME: begin
					if (is_name_char(char_in)) begin
						if (cnt >= CNT_MAX) begin
							r0      = mk(K_DROP, 8'd0, E_LONG, fill);
							nres    = 2'd1;
							mode_nx = M_SKIP;
						end else begin
							r0     = mk(K_NAME, char_in, E_NONE, fill);
							nres   = 2'd1;
							cnt_nx = cnt + 1'b1;
						end
					end else begin
						mode_nx   = M_BLANK;
						ctx_nx    = C_COLON;
						bctx      = C_COLON;
						run_blank = 1'b1;
					end
				end
				M_TEXT: begin
					if (char_in == CH_QUOTE) begin
						fill_nx = fill_inc;
						r0      = mk(K_TEXT, 8'd0, E_NONE, fill_inc);
						r1      = mk(K_DONE, 8'd0, E_NONE, fill_inc);
						nres    = 2'd2;
						mode_nx = M_BLANK;
						ctx_nx  = C_NAME;
					end else if (char_in == CH_BSL) begin
						mode_nx = M_ESC;
					end else begin
						fill_nx = fill_inc;
						r0      = mk(K_TEXT, char_in, E_NONE, fill_inc);
						nres    = 2'd1;
					end
				end
				M_ESC: begin
					mode_nx = M_TEXT;
					if (char_in == CH_CR) begin
						mode_nx = M_DROP;
					end else if (char_in != CH_LF) begin
						fill_nx = fill_inc;
						nres    = 2'd1;
						if (char_in == CH_N)
							r0 = mk(K_TEXT, CH_LF, E_NONE, fill_inc);
						else if (char_in == CH_T)
							r0 = mk(K_TEXT, CH_TAB, E_NONE, fill_inc);
						else
							r0 = mk(K_TEXT, char_in, E_NONE, fill_inc);
					end
				end
				M_DROP: begin
					mode_nx = M_TEXT;
				end
				M_SKIP: begin
					if (char_in == CH_LF) begin
						mode_nx = M_BLANK;
						ctx_nx  = C_NAME;
					end
				end
				default: begin
					mode_nx   = M_BLANK;
					ctx_nx    = C_NAME;
					bctx      = C_NAME;
					run_blank = 1'b1;
				end
			endcase

			// blank skipping between tokens, possibly as a second look at the char
			if (run_blank) begin
				if (blank_c) begin
					mode_nx = M_BLANK;
				end else if (char_in == CH_SLASH) begin
					mode_nx = M_SLASH;
				end else if (bctx == C_COLON) begin
					if (char_in == CH_COLON) begin
						ctx_nx = C_QUOTE;
					end else begin
						r0      = mk(K_DROP, 8'd0, E_NO_COLON, fill);
						nres    = 2'd1;
						mode_nx = M_SKIP;
					end
				end else if (bctx == C_QUOTE) begin
					if (char_in == CH_QUOTE) begin
						mode_nx = M_TEXT;
					end else begin
						r0      = mk(K_DROP, 8'd0, E_NO_QUOTE, fill);
						nres    = 2'd1;
						mode_nx = M_SKIP;
					end
				end else begin
					ctx_nx = C_NAME;
					if (is_name_char(char_in)) begin
						r0      = mk(K_NAME, char_in, E_NONE, fill);
						nres    = 2'd1;
						cnt_nx  = CNT_W'(1);
						mode_nx = M_NAME;
					end else begin
						r0      = mk(K_DROP, 8'd0, E_NO_NAME, fill);
						nres    = 2'd1;
						mode_nx = M_SKIP;
					end
				end
			end
		end

		r0.last = nres == 2'd1;
		r1.last = 1'b1;
	end

endmodule
`default_nettype wire

// File: hdl/stt_outq.sv
`default_nettype none
// Two-slot result queue; a request with two results drains slot 0 first, then slot 1.
module stt_outq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire logic [1:0]      push_n,
	input  wire stt_pkg::res_t   r0,
	input  wire stt_pkg::res_t   r1,
	output stt_pkg::q_stat_t     stat,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [31:0]          m_tdata, // out_byte, error_code, store_fill, zero pad
	output logic [1:0]           m_tuser, // kind
	output logic                 m_tlast
);
	import stt_pkg::*;

	logic [1:0] count_q;
	res_t       slot0_q;
	res_t       slot1_q;
	logic       pop;

	assign m_tvalid   = count_q != 2'd0;
	assign pop        = m_tvalid && m_tready;
	assign stat.count = count_q;
	assign stat.space = (count_q == 2'd0) || (count_q == 2'd1 && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (push) begin
			count_q <= push_n;
		end else if (pop) begin
			count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot0_q <= r0;
			slot1_q <= r1;
		end else if (pop) begin
			slot0_q <= slot1_q;
		end
	end

	assign m_tdata = {5'd0, slot0_q.fill, slot0_q.err, slot0_q.data};
	assign m_tuser = slot0_q.kind;
	assign m_tlast = slot0_q.last;

endmodule
`default_nettype wire

// File: hdl/string_table_text_tokenizer.sv
// Path: an accepted request waits in the input register, then its results go into the output queue.
// Throughput: one character per cycle while the output takes every result; a character that yields two results
//   (closing quote: terminator plus record-complete mark) holds the input stage
//   while the output queue drains its second slot.
// Reset: arst_n clears the parser state, store fill and both valid flags at once.
`default_nettype none
`include "string_table_text_tokenizer_assert.svh"
module string_table_text_tokenizer #(
	parameter int NAME_MAX    = stt_pkg::NAME_MAX_DEF,
	parameter int STORE_BYTES = stt_pkg::STORE_BYTES_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // char_in
	input  wire logic        s_tuser,  // end_of_input
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // out_byte [7:0], error_code [10:8],
	                                   // store_fill [26:11], zero [31:27]
	output logic [1:0]       m_tuser,  // kind
	output logic             m_tlast
);
	import stt_pkg::*;

	// Input register: one character request waits here while the parser
	// state and the output queue decide whether it can be consumed.
	logic              valid_s1;
	logic [7:0]        char_s1;
	logic              eoi_s1;

	// Parser state, advanced once per consumed request.
	mode_t             mode_q;
	ctx_t              ctx_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [FILL_W-1:0] fill_q;

	mode_t             mode_nx;
	ctx_t              ctx_nx;
	logic [CNT_W-1:0]  cnt_nx;
	logic [FILL_W-1:0] fill_nx;
	logic [1:0]        nres;
	res_t              r0;
	res_t              r1;
	q_stat_t           q_stat;

	logic              s_fire;
	logic              adv;

	// Consume the held request when the queue will be empty after this edge;
	// this keeps the results of one character together and in order.
	assign adv      = valid_s1 && q_stat.space;
	assign s_tready = !valid_s1 || q_stat.space;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			char_s1 <= s_tdata;
			eoi_s1  <= s_tuser;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_BLANK;
			ctx_q  <= C_NAME;
			cnt_q  <= '0;
			fill_q <= '0;
		end else if (adv) begin
			mode_q <= mode_nx;
			ctx_q  <= ctx_nx;
			cnt_q  <= cnt_nx;
			fill_q <= fill_nx;
		end
	end

	// Character decode: comments, name check, escapes, store fill.
	stt_step #(
		.NAME_MAX    (NAME_MAX),
		.STORE_BYTES (STORE_BYTES)
	) u_step (
		.char_in      (char_s1),
		.end_of_input (eoi_s1),
		.mode         (mode_q),
		.ctx          (ctx_q),
		.cnt          (cnt_q),
		.fill         (fill_q),
		.mode_nx      (mode_nx),
		.ctx_nx       (ctx_nx),
		.cnt_nx       (cnt_nx),
		.fill_nx      (fill_nx),
		.nres         (nres),
		.r0           (r0),
		.r1           (r1)
	);

	// Result register: up to two results per request.
	stt_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (adv),
		.push_n   (nres),
		.r0       (r0),
		.r1       (r1),
		.stat     (q_stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// A consumed request that yields results must show one on the next cycle.
	`STT_ASSERT_NEXT(a_res_shown, adv && nres != 2'd0, m_tvalid, "result not presented")
	// End of input wipes the store fill.
	`STT_ASSERT_NEXT(a_eoi_fill, adv && eoi_s1, fill_q == '0, "fill not cleared at end")
	// Fill moves only when a request is consumed.
	`STT_ASSERT_NEXT(a_fill_hold, !adv, $stable(fill_q), "fill moved without a request")
	// Record marks always close the results of their request.
	`STT_ASSERT_NOW(a_mark_last, m_tvalid && (m_tuser == K_DONE || m_tuser == K_DROP),
		m_tlast, "record mark without tlast")

endmodule
`default_nettype wire
